### hw/rtl/pi4_pkg.sv
`default_nettype none
package pi4_pkg;

  localparam logic [1:0] CMD_PIXEL = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_WORD = 1'b1;

  localparam logic [4:0] LIMIT_RESET = 5'd16;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic out_blocked;
  } dp_status_t;

endpackage
`default_nettype wire

### hw/rtl/palette_indexer_4bpp.sv
// An accepted input word is captured into the input registers, then executed, which writes
// any result word into the output register; execute waits while a finished result word
//   is stalled in the output register. No new input word is taken until execute is done.
// Reset (rst, synchronous, active high): palette empty, pairing and overflow
//   cleared, palette_limit set to 16, output empty. Palette entries are not cleared.
`default_nettype none
module palette_indexer_4bpp import pi4_pkg::*; #(
  parameter int PALETTE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [23:0] pixel_rgb,
  input  wire logic [3:0]  entry_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             kind,
  output logic [7:0]       packed_byte,
  output logic [15:0]      palette_word,
  output logic [4:0]       palette_count,
  output logic             overflow
);

  dp_cmd_t    command;
  dp_status_t status;

  pi4_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .command  (command)
  );

  pi4_datapath #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .command       (command),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .pixel_rgb     (pixel_rgb),
    .entry_index   (entry_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .packed_byte   (packed_byte),
    .palette_word  (palette_word),
    .palette_count (palette_count),
    .overflow      (overflow)
  );

endmodule
`default_nettype wire

### hw/rtl/pi4_ctrl.sv
`default_nettype none
module pi4_ctrl import pi4_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire dp_status_t status,
  output dp_cmd_t         command
);

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (!status.out_blocked) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    command.load = 1'b0;
    command.exec = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall     = 1'b0;
        command.load = in_valid;
      end
      ST_EXEC: begin
        // hold until the output register can take a word
        command.exec = !status.out_blocked;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/pi4_datapath.sv
`default_nettype none
module pi4_datapath import pi4_pkg::*; #(
  parameter int PALETTE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dp_cmd_t     command,
  output dp_status_t       status,
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_data,
  input  wire logic [1:0]  cmd,
  input  wire logic [23:0] pixel_rgb,
  input  wire logic [3:0]  entry_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             kind,
  output logic [7:0]       packed_byte,
  output logic [15:0]      palette_word,
  output logic [4:0]       palette_count,
  output logic             overflow
);

  localparam int         IDX_W    = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam logic [4:0] DEPTH_W5 = 5'(PALETTE_DEPTH);

  function automatic logic [15:0] swap_565(input logic [23:0] rgb);
    return {rgb[12:10], rgb[7:3], rgb[23:19], rgb[15:13]};
  endfunction

  logic [23:0] palette_store [PALETTE_DEPTH];
  logic [4:0]  color_count;
  logic [3:0]  held_nibble;
  logic        second_pending;
  logic        overflow_seen;
  logic [4:0]  palette_limit;

  logic [1:0]  cmd_q;
  logic [23:0] rgb_q;
  logic [3:0]  ei_q;

  logic [4:0]  limit_used;
  logic        any_hit;
  logic [3:0]  hit_idx;
  logic        do_add;
  logic [3:0]  pix_idx;
  logic [4:0]  count_next;
  logic        overflow_next;
  logic        emit;
  logic        out_valid_next;

  assign status.out_blocked = out_valid && out_stall;
  assign limit_used = (palette_limit < DEPTH_W5) ? palette_limit : DEPTH_W5;

  // parallel compare against every live entry, lowest index wins
  always_comb begin
    any_hit = 1'b0;
    hit_idx = 4'd0;
    for (int i = PALETTE_DEPTH - 1; i >= 0; i--) begin
      if ((5'(i) < color_count) && (palette_store[i] == rgb_q)) begin
        any_hit = 1'b1;
        hit_idx = 4'(i);
      end
    end
  end

  always_comb begin
    do_add        = 1'b0;
    pix_idx       = hit_idx;
    count_next    = color_count;
    overflow_next = overflow_seen;
    if (!any_hit) begin
      if (color_count < limit_used) begin
        do_add     = 1'b1;
        pix_idx    = color_count[3:0];
        count_next = color_count + 5'd1;
      end else begin
        pix_idx       = 4'd0;
        overflow_next = 1'b1;
      end
    end
  end

  always_comb begin
    emit = 1'b0;
    case (cmd_q)
      CMD_PIXEL: emit = second_pending;
      CMD_READ:  emit = 1'b1;
      default:   emit = 1'b0;
    endcase
  end

  always_comb begin
    if (command.exec && emit) begin
      out_valid_next = 1'b1;
    end else if (out_stall) begin
      out_valid_next = out_valid;
    end else begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (command.load) begin
      cmd_q <= cmd;
      rgb_q <= pixel_rgb;
      ei_q  <= entry_index;
    end
    if (command.exec && cmd_q == CMD_PIXEL && do_add) begin
      palette_store[color_count[IDX_W-1:0]] <= rgb_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      color_count    <= 5'd0;
      held_nibble    <= 4'd0;
      second_pending <= 1'b0;
      overflow_seen  <= 1'b0;
      palette_limit  <= LIMIT_RESET;
      out_valid      <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (cfg_we) palette_limit <= cfg_data;
      if (command.exec) begin
        case (cmd_q)
          CMD_PIXEL: begin
            color_count    <= count_next;
            overflow_seen  <= overflow_next;
            second_pending <= !second_pending;
            if (!second_pending) held_nibble <= pix_idx;
          end
          CMD_CLEAR: begin
            color_count    <= 5'd0;
            held_nibble    <= 4'd0;
            second_pending <= 1'b0;
            overflow_seen  <= 1'b0;
          end
          default: begin
            color_count <= color_count;
          end
        endcase
      end
    end
  end

  // output word payload
  always_ff @(posedge clk) begin
    if (command.exec && emit) begin
      if (cmd_q == CMD_PIXEL) begin
        kind          <= KIND_BYTE;
        packed_byte   <= {held_nibble, pix_idx};
        palette_word  <= 16'd0;
        palette_count <= count_next;
        overflow      <= overflow_next;
      end else begin
        kind          <= KIND_WORD;
        packed_byte   <= 8'd0;
        // reads past the live entries return a zero word
        if ({1'b0, ei_q} < color_count) begin
          palette_word <= swap_565(palette_store[ei_q[IDX_W-1:0]]);
        end else begin
          palette_word <= 16'd0;
        end
        palette_count <= color_count;
        overflow      <= overflow_seen;
      end
    end
  end

endmodule
`default_nettype wire

### sim/palette_indexer_4bpp_tb.sv
`timescale 1ns / 1ps
module palette_indexer_4bpp_tb import pi4_pkg::*;;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASE_WORDS = 150;
  localparam logic [1:0] CMD_IGNORED = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [7:0]  pbyte;
    logic [15:0] pword;
    logic [4:0]  fill;
    logic        ovf;
  } out_word_t;

  class index_scoreboard;
    logic [23:0] colors [16];
    logic [4:0]  fill;
    logic [3:0]  held;
    logic        pending;
    logic        ovf;
    logic [4:0]  limit;
    out_word_t   owed_words [$];
    int          errors;

    function new();
      fill = '0;
      held = '0;
      pending = 1'b0;
      ovf = 1'b0;
      limit = LIMIT_RESET;
      errors = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    // Advance the encoder state by one accepted input word.
    function void note_word(logic [1:0] op, logic [23:0] rgb, logic [3:0] sel);
      logic [4:0]  cap;
      logic [3:0]  idx;
      logic        hit;
      logic [23:0] c;
      out_word_t   e;
      cap = (limit > 5'd16) ? 5'd16 : limit;
      e = '0;
      case (op)
        CMD_PIXEL: begin
          hit = 1'b0;
          idx = '0;
          for (int i = 0; i < 16; i++) begin
            if (!hit && i < fill && colors[i] == rgb) begin
              hit = 1'b1;
              idx = i[3:0];
            end
          end
          if (!hit) begin
            if (fill < cap) begin
              idx = fill[3:0];
              colors[idx] = rgb;
              fill = fill + 5'd1;
            end else begin
              ovf = 1'b1;
            end
          end
          if (!pending) begin
            held = idx;
            pending = 1'b1;
          end else begin
            pending = 1'b0;
            e.kind = KIND_BYTE;
            e.pbyte = {held, idx};
            e.fill = fill;
            e.ovf = ovf;
            owed_words = {owed_words, e};
          end
        end
        CMD_READ: begin
          e.kind = KIND_WORD;
          if (sel < fill) begin
            c = colors[sel];
            // swapped RGB565: high byte g[4:2],b[7:3], low byte r[7:3],g[7:5]
            e.pword = {c[12:10], c[7:3], c[23:19], c[15:13]};
          end
          e.fill = fill;
          e.ovf = ovf;
          owed_words = {owed_words, e};
        end
        CMD_CLEAR: begin
          fill = '0;
          held = '0;
          pending = 1'b0;
          ovf = 1'b0;
        end
        default: ;
      endcase
    endfunction

    function void check_word(logic k, logic [7:0] b, logic [15:0] w, logic [4:0] n,
                             logic v);
      out_word_t x;
      if (owed_words.size() == 0) begin
        flag($sformatf("unexpected output word: kind %0d byte %02h word %04h count %0d ovf %0d",
                       k, b, w, n, v));
      end else begin
        x = owed_words.pop_front();
        if (k !== x.kind || b !== x.pbyte || w !== x.pword || n !== x.fill ||
            v !== x.ovf) begin
          flag($sformatf({"output mismatch: expected kind %0d byte %02h word %04h count %0d",
                          " ovf %0d, got kind %0d byte %02h word %04h count %0d ovf %0d"},
                         x.kind, x.pbyte, x.pword, x.fill, x.ovf, k, b, w, n, v));
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [4:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  cmd;
  logic [23:0] pixel_rgb;
  logic [3:0]  entry_index;
  logic        out_valid;
  logic        out_stall;
  logic        kind;
  logic [7:0]  packed_byte;
  logic [15:0] palette_word;
  logic [4:0]  palette_count;
  logic        overflow;

  bit          quiet = 1'b0;
  bit          hold_off = 1'b0;
  int unsigned cycle_count = 0;
  index_scoreboard sb = new();

  palette_indexer_4bpp uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .pixel_rgb(pixel_rgb),
    .entry_index(entry_index), .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .packed_byte(packed_byte), .palette_word(palette_word),
    .palette_count(palette_count), .overflow(overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  task automatic send_word(logic [1:0] op, logic [23:0] rgb, logic [3:0] sel);
    int g;
    in_valid <= 1'b1;
    cmd <= op;
    pixel_rgb <= rgb;
    entry_index <= sel;
    do @(posedge clk); while (in_stall);
    sb.note_word(op, rgb, sel);
    g = quiet ? 0 : pick_gap();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Let every owed word arrive, then give the datapath time to go idle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.owed_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_limit(logic [4:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.limit = v;
  endtask

  task automatic run_phase(int n);
    logic [23:0] pool [24];
    int          psize;
    int          sent;
    int          r;
    logic [23:0] rgb;
    psize = $urandom_range(3, 24);
    for (int i = 0; i < 24; i++) begin
      // some colors differ from the first by a single bit
      if (i > 0 && $urandom_range(0, 3) == 0) pool[i] = pool[0] ^ (24'd1 << $urandom_range(0, 23));
      else pool[i] = 24'($urandom());
    end
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_word(CMD_IGNORED, 24'($urandom()), 4'($urandom()));
      end else begin
        sent++;
        if (r < 6) begin
          send_word(CMD_CLEAR, 24'($urandom()), 4'($urandom()));
        end else if (r < 24) begin
          send_word(CMD_READ, 24'($urandom()), 4'($urandom()));
        end else begin
          rgb = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, psize - 1)]
                                              : 24'($urandom());
          send_word(CMD_PIXEL, rgb, 4'($urandom()));
        end
      end
    end
  endtask

  // Receiver: random stall, or one long hold-off on request.
  initial begin
    int g;
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        g = quiet ? 0 : pick_gap();
        out_stall <= (g != 0);
        repeat ((g == 0) ? 1 : g) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_word(kind, packed_byte, palette_word, palette_count, overflow);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("palette_indexer_4bpp regression: fail");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    cmd <= CMD_PIXEL;
    pixel_rgb <= '0;
    entry_index <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty palette, pairs in both orders, reads in and past the palette
    send_word(CMD_READ, 24'h000000, 4'd0);
    send_word(CMD_PIXEL, 24'h000000, 4'd0);
    send_word(CMD_PIXEL, 24'hFFFFFF, 4'd0);
    send_word(CMD_PIXEL, 24'hFFFFFF, 4'd15);
    send_word(CMD_PIXEL, 24'h000000, 4'd0);
    send_word(CMD_READ, 24'h000000, 4'd0);
    send_word(CMD_READ, 24'hFFFFFF, 4'd1);
    send_word(CMD_READ, 24'h000000, 4'd15);
    // clear drops a held first pixel; the unused command is ignored
    send_word(CMD_PIXEL, 24'hA5A5A5, 4'd0);
    send_word(CMD_CLEAR, 24'h000000, 4'd0);
    send_word(CMD_IGNORED, 24'hFFFFFF, 4'd15);
    send_word(CMD_PIXEL, 24'h123456, 4'd0);
    send_word(CMD_PIXEL, 24'h5A5A5A, 4'd0);
    send_word(CMD_READ, 24'h000000, 4'd1);
    drain();

    // limit below the current count, then a full palette of one
    set_limit(5'd1);
    send_word(CMD_PIXEL, 24'h112233, 4'd0);
    send_word(CMD_PIXEL, 24'h123456, 4'd0);
    send_word(CMD_CLEAR, 24'h000000, 4'd0);
    send_word(CMD_PIXEL, 24'hF81CF8, 4'd0);
    send_word(CMD_PIXEL, 24'h07E307, 4'd0);
    send_word(CMD_READ, 24'h000000, 4'd0);
    drain();

    // no color can be added
    set_limit(5'd0);
    send_word(CMD_CLEAR, 24'h000000, 4'd0);
    send_word(CMD_PIXEL, 24'h000000, 4'd0);
    send_word(CMD_PIXEL, 24'h000000, 4'd0);
    send_word(CMD_READ, 24'h000000, 4'd0);
    drain();

    set_limit(5'd31);
    hold_off = 1'b1;
    run_phase(PHASE_WORDS);
    drain();
    set_limit(5'd16);
    quiet = 1'b1;
    run_phase(PHASE_WORDS);
    drain();
    quiet = 1'b0;
    set_limit(5'd1);
    run_phase(PHASE_WORDS);
    drain();
    set_limit(5'd0);
    run_phase(PHASE_WORDS / 2);
    drain();
    set_limit(5'($urandom_range(2, 15)));
    run_phase(PHASE_WORDS);
    drain();
    set_limit(5'($urandom_range(17, 30)));
    run_phase(PHASE_WORDS);
    drain();
    set_limit(5'($urandom_range(0, 31)));
    run_phase(PHASE_WORDS);
    drain();
    set_limit(5'd16);
    run_phase(PHASE_WORDS);
    drain();

    if (sb.errors == 0) begin
      $display("palette_indexer_4bpp regression: pass");
    end else begin
      $display("palette_indexer_4bpp regression: fail");
    end
    $finish;
  end

endmodule
